// File: sv/hex_record_line_parser_unit_assert.svh
// Assertion macros used by the checker file hrlp_checker.
`ifndef HEX_RECORD_LINE_PARSER_UNIT_ASSERT_SVH
`define HEX_RECORD_LINE_PARSER_UNIT_ASSERT_SVH

// Assert a property on every clock edge outside reset.
`define HRLP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assert a property on every clock edge, reset included.
`define HRLP_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/hrlp_pkg.sv
package hrlp_pkg;

  localparam int MaxSizeDefault = 255;
  localparam int IntelMinChars  = 11;
  localparam int SrecMinChars   = 10;

  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChS     = 8'h53;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] CaseBit = 8'h20;

  typedef enum logic [3:0] {
    P_START, P_I_SIZE, P_I_ADDR, P_I_TYPE, P_S_TYPE,
    P_S_COUNT, P_S_ADDR, P_DATA, P_CKSUM, P_EOL
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK, ST_SHORT, ST_NOSTART, ST_NOTHEX, ST_TYPE, ST_SIZE, ST_CKSUM, ST_EOL
  } status_t;

  localparam logic [2:0] FMT_I8  = 3'd0;
  localparam logic [2:0] FMT_I16 = 3'd1;
  localparam logic [2:0] FMT_I32 = 3'd2;
  localparam logic [2:0] FMT_S19 = 3'd3;
  localparam logic [2:0] FMT_S28 = 3'd4;
  localparam logic [2:0] FMT_S37 = 3'd5;

  // One result item
  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic [3:0]  rec_type;
    logic [31:0] address;
    logic [7:0]  size;
    logic [31:0] value;
    logic [2:0]  status;
    logic [9:0]  chars_used;
    logic        last;
  } result_t;

  // Decode an ASCII hex digit; bit 4 flags a valid digit
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [7:0] l;
    l = c | CaseBit;
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, c[3:0]};
    if (l >= 8'h61 && l <= 8'h66) return {1'b1, 4'(l[3:0] + 4'd9)};
    return 5'd0;
  endfunction

endpackage

// File: sv/hrlp_core.sv
// Per-character record state: next-state and result logic.
module hrlp_core #(
  parameter int MAX_SIZE = hrlp_pkg::MaxSizeDefault
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [2:0]           format,
  input  logic                 step,
  input  logic [7:0]           ch,
  input  logic                 text_end,
  output logic                 res_valid,
  output hrlp_pkg::result_t    res
);
  import hrlp_pkg::*;

  localparam logic [7:0] MaxSz = 8'(MAX_SIZE);

  phase_t      phase_r, phase_nxt;
  logic [3:0]  hi_r, hi_nxt;
  logic        odd_r, odd_nxt;
  logic [7:0]  rsize_r, rsize_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [3:0]  rkind_r, rkind_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [31:0] pack_r, pack_nxt;
  logic [9:0]  cnt_r, cnt_nxt;
  logic        skip_r, skip_nxt;
  logic        acr_r, acr_nxt;

  logic        intel, done, data, cksum_ok, is_line;
  status_t     st;
  logic [7:0]  b, dbyte, didx, asz, bsum, s_rem;
  logic [4:0]  hx;
  logic [7:0]  lim;
  logic        type_ok;

  always_comb begin
    intel    = format < FMT_S19;
    lim      = intel ? 8'(IntelMinChars) : 8'(SrecMinChars);
    hx       = hex_decode(ch);
    b        = {hi_r, hx[3:0]};
    bsum     = sum_r + b;
    is_line  = (ch == ChCr) || (ch == ChLf);
    cksum_ok = intel ? (sum_r == 8'h00) : (sum_r == 8'hFF);
    case (rkind_r)
      4'd2, 4'd6, 4'd8: asz = 8'd3;
      4'd3, 4'd7:       asz = 8'd4;
      default:          asz = 8'd2;
    endcase
    s_rem = b - asz - 8'd1;
    phase_nxt = phase_r; hi_nxt = hi_r; odd_nxt = odd_r; rsize_nxt = rsize_r;
    addr_nxt = addr_r; rkind_nxt = rkind_r; sum_nxt = sum_r; left_nxt = left_r;
    pack_nxt = pack_r; cnt_nxt = cnt_r; skip_nxt = skip_r; acr_nxt = acr_r;
    done = 1'b0; data = 1'b0; st = ST_OK; dbyte = '0; didx = '0; type_ok = 1'b0;
    res_valid = 1'b0;
    res = '0;

    if (step) begin
      // Swallow the line feed of a CR LF pair
      if (acr_r) acr_nxt = 1'b0;
      if (acr_r && ch == ChLf && phase_r == P_START && !skip_r) begin
        // nothing
      end else if (skip_r) begin
        // Drop characters up to the line break
        if (ch == ChCr) begin
          skip_nxt = 1'b0; acr_nxt = !text_end;
        end else if (ch == ChLf) skip_nxt = 1'b0;
        if (text_end) begin
          skip_nxt = 1'b0; acr_nxt = 1'b0;
        end
      end else begin
        if (cnt_r != 10'h3FF) cnt_nxt = cnt_r + 10'd1;
        if (phase_r == P_START) begin
          if (ch == (intel ? ChColon : ChS)) phase_nxt = intel ? P_I_SIZE : P_S_TYPE;
          else begin
            done = 1'b1; st = ST_NOSTART;
          end
        end else if (phase_r == P_EOL) begin
          done = 1'b1;
          if (is_line) begin
            st = cksum_ok ? ST_OK : ST_CKSUM;
            if (ch == ChCr && !text_end) acr_nxt = 1'b1;
          end else st = (rsize_r < MaxSz) ? ST_SIZE : ST_EOL;
        end else if (!hx[4]) begin
          done = 1'b1;
          st = ((phase_r == P_DATA || phase_r == P_CKSUM) && !odd_r && is_line)
               ? ST_SIZE : ST_NOTHEX;
        end else if (phase_r == P_S_TYPE) begin
          rkind_nxt = hx[3:0];
          case (hx[3:0])
            4'd0, 4'd5: type_ok = 1'b1;
            4'd1, 4'd9: type_ok = format == FMT_S19;
            4'd2, 4'd8: type_ok = format == FMT_S28;
            4'd3, 4'd7: type_ok = format == FMT_S37;
            4'd6:       type_ok = format != FMT_S19;
            default:    type_ok = 1'b0;
          endcase
          if (!type_ok) begin
            done = 1'b1; st = ST_TYPE;
          end else phase_nxt = P_S_COUNT;
        end else if (!odd_r) begin
          hi_nxt = hx[3:0]; odd_nxt = 1'b1;
        end else begin
          odd_nxt = 1'b0;
          case (phase_r)
            P_I_SIZE: begin
              rsize_nxt = b; sum_nxt = bsum; left_nxt = 8'd2; phase_nxt = P_I_ADDR;
            end
            P_I_ADDR, P_S_ADDR: begin
              addr_nxt = {addr_r[23:0], b}; sum_nxt = bsum; left_nxt = left_r - 8'd1;
              if (left_r == 8'd1) begin
                if (phase_r == P_S_ADDR && rkind_r > 4'd3 && rsize_r != 8'd0) begin
                  done = 1'b1; st = ST_SIZE;
                end else begin
                  left_nxt = rsize_r;
                  phase_nxt = (rsize_r != 8'd0) ? P_DATA : P_CKSUM;
                end
              end
            end
            P_I_TYPE: begin
              rkind_nxt = (b > 8'd15) ? 4'd15 : b[3:0];
              case (b)
                8'd0, 8'd1: type_ok = 1'b1;
                8'd2, 8'd3: type_ok = format == FMT_I16;
                8'd4, 8'd5: type_ok = format == FMT_I32;
                default:    type_ok = 1'b0;
              endcase
              if (!type_ok) begin
                done = 1'b1; st = ST_TYPE;
              end else begin
                sum_nxt = bsum;
                if ((b == 8'd1 && rsize_r != 8'd0) ||
                    ((b == 8'd2 || b == 8'd4) && rsize_r < 8'd2) ||
                    ((b == 8'd3 || b == 8'd5) && rsize_r < 8'd4) ||
                    rsize_r > MaxSz) begin
                  done = 1'b1; st = ST_SIZE;
                end else begin
                  left_nxt = rsize_r;
                  phase_nxt = (rsize_r != 8'd0) ? P_DATA : P_CKSUM;
                end
              end
            end
            P_S_COUNT: begin
              sum_nxt = bsum;
              if (b < asz + 8'd1 || s_rem > MaxSz) begin
                done = 1'b1; st = ST_SIZE;
              end else begin
                rsize_nxt = s_rem; left_nxt = asz; phase_nxt = P_S_ADDR;
              end
            end
            P_DATA: begin
              didx = rsize_r - left_r;
              if (intel && (((rkind_r == 4'd2 || rkind_r == 4'd4) && didx < 8'd2) ||
                            ((rkind_r == 4'd3 || rkind_r == 4'd5) && didx < 8'd4)))
                pack_nxt = {pack_r[23:0], b};
              sum_nxt = bsum; left_nxt = left_r - 8'd1;
              if (left_r == 8'd1) phase_nxt = P_CKSUM;
              data = 1'b1; dbyte = b;
            end
            default: begin
              sum_nxt = bsum; phase_nxt = P_EOL;
              if (text_end) begin
                done = 1'b1;
                st = (intel ? (bsum == 8'h00) : (bsum == 8'hFF)) ? ST_OK : ST_CKSUM;
              end
            end
          endcase
        end

        // End of text closes the record
        if (text_end) begin
          if (!done) st = ({6'd0, cnt_nxt} < {8'd0, lim}) ? ST_SHORT : ST_SIZE;
          else if (st != ST_OK && {6'd0, cnt_nxt} < {8'd0, lim}) st = ST_SHORT;
          done = 1'b1;
        end

        res.rec_type = rkind_nxt; res.address = addr_nxt; res.size = rsize_nxt;
        res.value = pack_nxt; res.chars_used = cnt_nxt;
        if (done) begin
          res_valid = 1'b1; res.kind = 1'b1; res.last = 1'b1; res.status = st;
          if (st != ST_OK && !text_end) begin
            if (ch == ChCr) acr_nxt = 1'b1;
            else if (ch != ChLf) skip_nxt = 1'b1;
          end
          if (text_end) begin
            skip_nxt = 1'b0; acr_nxt = 1'b0;
          end
          phase_nxt = P_START; hi_nxt = '0; odd_nxt = 1'b0; rsize_nxt = '0;
          addr_nxt = '0; rkind_nxt = '0; sum_nxt = '0; left_nxt = '0;
          pack_nxt = '0; cnt_nxt = '0;
        end else if (data) begin
          res_valid = 1'b1; res.data_byte = dbyte; res.byte_index = didx;
        end
      end
    end
  end

  // Hold record state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_START; hi_r <= '0; odd_r <= 1'b0; rsize_r <= '0; addr_r <= '0;
      rkind_r <= '0; sum_r <= '0; left_r <= '0; pack_r <= '0; cnt_r <= '0;
      skip_r <= 1'b0; acr_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt; hi_r <= hi_nxt; odd_r <= odd_nxt; rsize_r <= rsize_nxt;
      addr_r <= addr_nxt; rkind_r <= rkind_nxt; sum_r <= sum_nxt; left_r <= left_nxt;
      pack_r <= pack_nxt; cnt_r <= cnt_nxt; skip_r <= skip_nxt; acr_r <= acr_nxt;
    end
  end

endmodule

// File: sv/hex_record_line_parser_unit.sv
// Intel HEX / Motorola S-record parser taking one ASCII character per item.
// Throughput is one character per cycle while the output is not stalled:
// each character is captured in an input register at acceptance, decoded
// combinationally by hrlp_core and captured in a result register, from
// which the result item is presented. The input side stalls only when
// the result register holds an item not yet taken.
module hex_record_line_parser_unit #(
  parameter int MAX_SIZE = hrlp_pkg::MaxSizeDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data,       // format
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // ch
  input  logic        s_axis_tlast,   // text_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [103:0] m_axis_tdata,  // data_byte, byte_index, address, size,
                                      // value, status, chars_used, zero fill
  output logic [4:0]  m_axis_tuser,   // kind, rec_type
  output logic        m_axis_tlast    // last
);
  import hrlp_pkg::*;

  logic        in_v_r;
  logic [7:0]  ch_r;
  logic        te_r;
  logic [2:0]  fmt_r;
  logic        out_v_r;
  result_t     out_r;
  logic        res_valid, stall;
  result_t     res;

  assign cfg_ready     = 1'b1;
  assign stall         = out_v_r && !m_axis_tready;
  assign s_axis_tready = !(in_v_r && stall);

  hrlp_core #(.MAX_SIZE(MAX_SIZE)) u_core (
    .clk(clk), .rst_n(rst_n), .format(fmt_r), .step(in_v_r && !stall),
    .ch(ch_r), .text_end(te_r), .res_valid(res_valid), .res(res)
  );

  // Register the configuration
  always_ff @(posedge clk) begin
    if (!rst_n) fmt_r <= FMT_I8;
    else if (cfg_valid) fmt_r <= cfg_data;
  end

  // Advance the input and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0; out_v_r <= 1'b0;
    end else begin
      if (s_axis_tready) in_v_r <= s_axis_tvalid;
      if (!stall) out_v_r <= in_v_r && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready) begin
      ch_r <= s_axis_tdata; te_r <= s_axis_tlast;
    end
    if (!stall) out_r <= res;
  end

  assign m_axis_tvalid = out_v_r;
  assign m_axis_tdata  = {3'd0, out_r.chars_used, out_r.status, out_r.value,
                          out_r.size, out_r.address, out_r.byte_index, out_r.data_byte};
  assign m_axis_tuser  = {out_r.rec_type, out_r.kind};
  assign m_axis_tlast  = out_r.last;

endmodule

// File: sv/hrlp_checker.sv
`include "hex_record_line_parser_unit_assert.svh"
// Port-level checks of the parser.
module hrlp_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [103:0] m_axis_tdata,
  input logic [4:0]   m_axis_tuser,
  input logic         m_axis_tlast
);
  `HRLP_ASSERT(a_out_hold, clk, rst_n,
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata),
    "result item changed while stalled")
  `HRLP_ASSERT(a_last_kind, clk, rst_n,
    m_axis_tvalid |-> (m_axis_tlast == m_axis_tuser[0]),
    "last and kind disagree")
  `HRLP_ASSERT(a_data_ok, clk, rst_n,
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[90:88] == 3'd0,
    "data item carries an error status")
  `HRLP_ASSERT(a_ready_free, clk, rst_n,
    !m_axis_tvalid |-> s_axis_tready,
    "input stalled with empty result register")
  `HRLP_ASSERT_ALWAYS(a_no_valid_rst, clk,
    !rst_n |=> !m_axis_tvalid,
    "result valid after reset")
endmodule

bind hex_record_line_parser_unit hrlp_checker u_hrlp_checker (.*);
